// ===== sv/fcd_pkg.sv =====
// Shared types, constants and codes for the fixed CAN frame deframer.
`default_nettype none
package fcd_pkg;

  localparam int FRAME_BYTES = 20;
  localparam int POS_W       = 5;
  localparam int CFG_IDX_W   = 8;

  localparam logic [POS_W-1:0] POS_START     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HEADER    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TYPE      = POS_W'(2);
  localparam logic [POS_W-1:0] POS_FTYPE     = POS_W'(3);
  localparam logic [POS_W-1:0] POS_FORMAT    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_ID_FIRST  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_ID_LAST   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_LENGTH    = POS_W'(9);
  localparam logic [POS_W-1:0] POS_DATA_LAST = POS_W'(17);
  localparam logic [POS_W-1:0] POS_CHECKSUM  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_MAX       = POS_W'(31);

  localparam logic [7:0] MAX_LENGTH_CODE = 8'd8;
  localparam logic [28:0] STD_ID_MASK = 29'h7FF;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_BAD_LENGTH = 3'd1;
  localparam logic [2:0] STATUS_BAD_HEADER = 3'd2;
  localparam logic [2:0] STATUS_BAD_DLC    = 3'd3;
  localparam logic [2:0] STATUS_BAD_SUM    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_VALUE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STD_TYPE_CODE  = CFG_IDX_W'(3);

  typedef struct packed {
    logic [7:0] start_value;
    logic [7:0] header_value;
    logic [7:0] reserved_value;
    logic [7:0] standard_type_code;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       sum;
    logic             header_good;
    logic [7:0]       type_code;
    logic [7:0]       frame_type_code;
    logic [7:0]       format_code;
    logic [28:0]      ident;
    logic [7:0]       length_code;
    logic [63:0]      payload;
    logic [7:0]       checksum;
  } frame_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  type_code;
    logic [7:0]  frame_type_code;
    logic [7:0]  format_code;
    logic [28:0] can_identifier;
    logic [7:0]  length_code;
    logic [63:0] payload;
    logic [7:0]  received_checksum;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/fcd_ifs.sv =====
// Byte input and result output channel interfaces.
`default_nettype none
interface fcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface fcd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  type_code;
  logic [7:0]  frame_type_code;
  logic [7:0]  format_code;
  logic [28:0] can_identifier;
  logic [7:0]  length_code;
  logic [63:0] payload;
  logic [7:0]  received_checksum;
  modport source (output valid, output status, output type_code, output frame_type_code,
                  output format_code, output can_identifier, output length_code,
                  output payload, output received_checksum, input ready);
  modport sink   (input valid, input status, input type_code, input frame_type_code,
                  input format_code, input can_identifier, input length_code,
                  input payload, input received_checksum, output ready);
endinterface
`default_nettype wire

// ===== sv/fixed_can_frame_deframer_unit.sv =====
// The closing byte passes the input register, then the result register.
// Throughput: one byte per cycle unless a closing byte stalls; the input and
// result registers are parted so bytes keep flowing while a result waits.
// A closing byte stalls only while the result register holds an untaken result.
// Reset (rst, synchronous): config returns to defaults, frame state clears,
// no request pending on either channel.
`default_nettype none
module fixed_can_frame_deframer_unit
  import fcd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  fcd_byte_if.sink                  byte_ch,
  fcd_result_if.source              result_ch
);

  cfg_t    cfg;
  logic    s1_valid;
  logic    [7:0] s1_byte;
  logic    s1_last;
  logic    s1_adv;
  frame_t  taken;
  result_t result;
  result_t out_reg;
  logic    out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_value        <= 8'd170;
      cfg.header_value       <= 8'd85;
      cfg.reserved_value     <= 8'd0;
      cfg.standard_type_code <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_VALUE:    cfg.start_value        <= cfg_data;
        REG_HEADER_VALUE:   cfg.header_value       <= cfg_data;
        REG_RESERVED_VALUE: cfg.reserved_value     <= cfg_data;
        REG_STD_TYPE_CODE:  cfg.standard_type_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv = s1_valid && (!s1_last || !out_valid || result_ch.ready);
  assign byte_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.ready && byte_ch.valid) begin
      s1_byte <= byte_ch.byte_value;
      s1_last <= byte_ch.last_byte;
    end
  end

  fcd_frame_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_adv),
    .byte_value (s1_byte),
    .last_byte  (s1_last),
    .cfg        (cfg),
    .taken      (taken)
  );

  fcd_result u_result (
    .taken  (taken),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) out_reg <= result;
  end

  assign result_ch.valid             = out_valid;
  assign result_ch.status            = out_reg.status;
  assign result_ch.type_code         = out_reg.type_code;
  assign result_ch.frame_type_code   = out_reg.frame_type_code;
  assign result_ch.format_code       = out_reg.format_code;
  assign result_ch.can_identifier    = out_reg.can_identifier;
  assign result_ch.length_code       = out_reg.length_code;
  assign result_ch.payload           = out_reg.payload;
  assign result_ch.received_checksum = out_reg.received_checksum;

endmodule
`default_nettype wire

// ===== sv/fcd_frame_acc.sv =====
// Frame accumulator: byte position, running sum, header check and field capture.
`default_nettype none
module fcd_frame_acc
  import fcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [7:0] byte_value,
  input  wire logic       last_byte,
  input  wire cfg_t       cfg,
  output frame_t          taken
);

  frame_t frame;
  frame_t frame_next;
  logic [POS_W-1:0] id_off;
  logic [POS_W-1:0] data_off;

  assign id_off   = frame.pos - POS_ID_FIRST;
  assign data_off = frame.pos - POS_LENGTH - POS_W'(1);

  always_comb begin
    taken = frame;
    if ((frame.pos >= POS_TYPE) && (frame.pos <= POS_DATA_LAST)) begin
      taken.sum = frame.sum + byte_value;
    end
    priority if (frame.pos == POS_START) begin
      if (byte_value != cfg.start_value) taken.header_good = 1'b0;
    end else if (frame.pos == POS_HEADER) begin
      if (byte_value != cfg.header_value) taken.header_good = 1'b0;
    end else if (frame.pos == POS_TYPE) begin
      taken.type_code = byte_value;
    end else if (frame.pos == POS_FTYPE) begin
      taken.frame_type_code = byte_value;
    end else if (frame.pos == POS_FORMAT) begin
      taken.format_code = byte_value;
    end else if (frame.pos < POS_ID_LAST) begin
      taken.ident[8*id_off[1:0] +: 8] = byte_value;
    end else if (frame.pos == POS_ID_LAST) begin
      taken.ident[28:24] = byte_value[4:0];
    end else if (frame.pos == POS_LENGTH) begin
      taken.length_code = byte_value;
    end else if (frame.pos <= POS_DATA_LAST) begin
      taken.payload[8*data_off[2:0] +: 8] = byte_value;
    end else if (frame.pos == POS_CHECKSUM) begin
      taken.checksum = byte_value;
    end else begin
      taken.sum = taken.sum;
    end
  end

  always_comb begin
    frame_next = taken;
    if (frame.pos != POS_MAX) frame_next.pos = frame.pos + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      frame <= '{header_good: 1'b1, default: '0};
    end else if (advance) begin
      frame <= frame_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fcd_result.sv =====
// Status checks and result field selection for a closed frame.
`default_nettype none
module fcd_result
  import fcd_pkg::*;
(
  input  wire frame_t taken,
  input  wire cfg_t   cfg,
  output result_t     result
);

  logic [7:0] expect_sum;
  logic [2:0] status;

  assign expect_sum = taken.sum + cfg.reserved_value;

  always_comb begin
    priority if (taken.pos != POS_CHECKSUM) status = STATUS_BAD_LENGTH;
    else if (!taken.header_good)            status = STATUS_BAD_HEADER;
    else if (taken.length_code > MAX_LENGTH_CODE) status = STATUS_BAD_DLC;
    else if (taken.checksum != expect_sum)  status = STATUS_BAD_SUM;
    else                                    status = STATUS_OK;
  end

  always_comb begin
    result = '0;
    result.status = status;
    if ((status != STATUS_BAD_LENGTH) && (status != STATUS_BAD_HEADER)) begin
      result.type_code         = taken.type_code;
      result.frame_type_code   = taken.frame_type_code;
      result.format_code       = taken.format_code;
      result.can_identifier    = (taken.frame_type_code == cfg.standard_type_code) ?
                                 (taken.ident & STD_ID_MASK) : taken.ident;
      result.length_code       = taken.length_code;
      result.payload           = taken.payload;
      result.received_checksum = taken.checksum;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fcd_checker.sv =====
// Port-level assertions for the deframer and their bind to the top level.
`default_nettype none
module fcd_checker
  import fcd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [28:0] can_identifier,
  input wire logic [7:0]  length_code,
  input wire logic [63:0] payload,
  input wire logic [7:0]  received_checksum
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= STATUS_BAD_SUM)
    else $error("status code out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_BAD_LENGTH || status == STATUS_BAD_HEADER) |->
      can_identifier == '0 && payload == '0 && length_code == '0 &&
      received_checksum == '0)
    else $error("rejected frame carries field data");

  a_ok_dlc: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> length_code <= MAX_LENGTH_CODE)
    else $error("ok status with length code over limit");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result request after reset");

endmodule

bind fixed_can_frame_deframer_unit fcd_checker u_fcd_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (result_ch.valid),
  .out_ready         (result_ch.ready),
  .status            (result_ch.status),
  .can_identifier    (result_ch.can_identifier),
  .length_code       (result_ch.length_code),
  .payload           (result_ch.payload),
  .received_checksum (result_ch.received_checksum)
);
`default_nettype wire
